// ===== design/dq_pkg.sv =====
// Shared types and constants for the double-ended queue unit.
// Used by dq_front, dq_back and the top level; depends on nothing.
package dq_pkg;

	// Default number of queue entries
	localparam int DQ_DEPTH = 32;

	// Width of the value path and of the result fields
	localparam int VAL_W   = 32;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 6;

	// Command codes on the cmd port
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP_FWD   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DUMP_REV   = 3'd5;

	// Status codes on the status port
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Depth of the command queue between front and back
	localparam int QD   = 2;
	localparam int QPW  = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW  = $clog2(QD + 1);

	// Decoded operation handed from front to back
	typedef enum logic [2:0] {
		OP_PUSH_F,
		OP_PUSH_B,
		OP_POP_F,
		OP_POP_B,
		OP_DUMP_F,
		OP_DUMP_R
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [VAL_W-1:0]  value;
	} q_item_t;

endpackage

// ===== design/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/dq_front.sv =====
// Front end: accepts items, decodes the command and queues the operation.
// Depends on dq_pkg.
module dq_front import dq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VAL_W-1:0]   value,
	output q_item_t            q_item,
	output logic               q_valid,
	input  logic               q_take
);

	q_item_t          fifo_q [QD];
	logic [QPW-1:0]   wr_q;
	logic [QPW-1:0]   rd_q;
	logic [QCW-1:0]   fill_q;
	op_t              op_dec;
	logic             keep;
	logic             wr_en;

	// Decode; unused codes are accepted and dropped
	always_comb begin
		keep   = 1'b1;
		op_dec = OP_PUSH_F;
		case (cmd)
			CMD_PUSH_FRONT: op_dec = OP_PUSH_F;
			CMD_PUSH_BACK:  op_dec = OP_PUSH_B;
			CMD_POP_FRONT:  op_dec = OP_POP_F;
			CMD_POP_BACK:   op_dec = OP_POP_B;
			CMD_DUMP_FWD:   op_dec = OP_DUMP_F;
			CMD_DUMP_REV:   op_dec = OP_DUMP_R;
			default:        keep   = 1'b0;
		endcase
	end

	assign busy    = (fill_q == QCW'(QD));
	assign q_valid = (fill_q != '0);
	assign q_item  = fifo_q[rd_q];
	assign wr_en   = start && !busy && keep;

	// Queue payload
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_q] <= '{op: op_dec, value: value};
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == QPW'(QD - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_take) begin
				rd_q <= (rd_q == QPW'(QD - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({wr_en, q_take})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== design/dq_back.sv =====
// Back end: executes queued operations on the ring buffer and drives results.
// Depends on dq_pkg and dq_ram.
module dq_back import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  q_item_t                   q_item,
	input  logic                      q_valid,
	output logic                      q_take,
	output logic                      strobe,
	output logic signed [VAL_W-1:0]   value_res,
	output logic [STAT_W-1:0]         status,
	output logic                      last,
	output logic [COUNT_W-1:0]        count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {B_RUN, B_DUMP} bstate_t;

	bstate_t            state_q, state_n;
	logic [PW-1:0]      f_q, f_n;
	logic [PW-1:0]      b_q, b_n;
	logic [CW-1:0]      cnt_q, cnt_n;
	logic [PW-1:0]      idx_q, idx_n;
	logic [CW-1:0]      left_q, left_n;
	logic               dir_q, dir_n;
	logic               vld_s1, vld_n;
	logic [STAT_W-1:0]  status_s1, status_n;
	logic               last_s1, last_n;
	logic               ram_s1, ram_n;
	logic [CW-1:0]      count_s1;
	logic               we;
	logic [PW-1:0]      waddr;
	logic [PW-1:0]      raddr;
	logic [VAL_W-1:0]   rdata;
	logic [PW-1:0]      f_dec;
	logic [PW-1:0]      b_dec;
	logic [PW-1:0]      step;
	logic               full;
	logic               empty;
	logic [CW+COUNT_W-1:0] count_ext;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
	endfunction

	dq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (q_item.value),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign f_dec  = ptr_dec(f_q);
	assign b_dec  = ptr_dec(b_q);
	assign step   = dir_q ? ptr_inc(idx_q) : ptr_dec(idx_q);
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign q_take = (state_q == B_RUN) && q_valid;

	// Operation issue: pointer updates, RAM access and next result fields
	always_comb begin
		state_n  = state_q;
		f_n      = f_q;
		b_n      = b_q;
		cnt_n    = cnt_q;
		idx_n    = idx_q;
		left_n   = left_q;
		dir_n    = dir_q;
		we       = 1'b0;
		waddr    = b_q;
		raddr    = idx_q;
		vld_n    = 1'b0;
		status_n = ST_OK;
		last_n   = 1'b1;
		ram_n    = 1'b0;
		case (state_q)
			B_RUN: begin
				if (q_valid) begin
					vld_n = 1'b1;
					case (q_item.op)
						OP_PUSH_F: begin
							if (full) begin
								status_n = ST_FULL;
							end else begin
								f_n   = f_dec;
								we    = 1'b1;
								waddr = f_dec;
								cnt_n = cnt_q + 1'b1;
							end
						end
						OP_PUSH_B: begin
							if (full) begin
								status_n = ST_FULL;
							end else begin
								b_n   = ptr_inc(b_q);
								we    = 1'b1;
								waddr = b_q;
								cnt_n = cnt_q + 1'b1;
							end
						end
						OP_POP_F: begin
							if (empty) begin
								status_n = ST_EMPTY;
							end else begin
								raddr = f_q;
								ram_n = 1'b1;
								f_n   = ptr_inc(f_q);
								cnt_n = cnt_q - 1'b1;
							end
						end
						OP_POP_B: begin
							if (empty) begin
								status_n = ST_EMPTY;
							end else begin
								raddr = b_dec;
								ram_n = 1'b1;
								b_n   = b_dec;
								cnt_n = cnt_q - 1'b1;
							end
						end
						OP_DUMP_F, OP_DUMP_R: begin
							if (empty) begin
								status_n = ST_EMPTY;
							end else begin
								dir_n  = (q_item.op == OP_DUMP_F);
								raddr  = (q_item.op == OP_DUMP_F) ? f_q : b_dec;
								idx_n  = raddr;
								ram_n  = 1'b1;
								last_n = (cnt_q == CW'(1));
								left_n = cnt_q - 1'b1;
								if (cnt_q != CW'(1)) begin
									state_n = B_DUMP;
								end
							end
						end
						default: vld_n = 1'b0;
					endcase
				end
			end
			B_DUMP: begin
				// one entry read per cycle until the walk is done
				raddr  = step;
				idx_n  = step;
				vld_n  = 1'b1;
				ram_n  = 1'b1;
				last_n = (left_q == CW'(1));
				left_n = left_q - 1'b1;
				if (left_q == CW'(1)) begin
					state_n = B_RUN;
				end
			end
			default: state_n = B_RUN;
		endcase
	end

	// State, pointers and result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_RUN;
			f_q     <= '0;
			b_q     <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_n;
			f_q     <= f_n;
			b_q     <= b_n;
			cnt_q   <= cnt_n;
			vld_s1  <= vld_n;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_q     <= idx_n;
		left_q    <= left_n;
		dir_q     <= dir_n;
		status_s1 <= status_n;
		last_s1   <= last_n;
		ram_s1    <= ram_n;
		count_s1  <= cnt_n;
	end

	// Result ports; the count field keeps its low six bits
	assign count_ext = {{COUNT_W{1'b0}}, count_s1};
	assign strobe    = vld_s1;
	assign status    = status_s1;
	assign last      = last_s1;
	assign count     = count_ext[COUNT_W-1:0];
	assign value_res = ram_s1 ? rdata
		: ((status_s1 == ST_EMPTY) ? {VAL_W{1'b1}} : '0);

endmodule

// ===== design/double_ended_queue_unit.sv =====
// Double-ended queue unit: top level joining the command front end and the executor.
// Depends on dq_pkg, dq_front, dq_back (and dq_ram below it).
// With the executor idle, an accepted item passes through the command queue and then the result stage registers.
// Throughput: pushes and pops run one per cycle unless a dump holds the executor; a dump of n entries keeps the
// executor for n RAM reads, one per entry, while the two-entry command queue fills and raises busy.
// Reset clears pointers, count and queue; entries stay undefined. Results cannot be held off.
module double_ended_queue_unit import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [CMD_W-1:0]          cmd,
	input  logic signed [VAL_W-1:0]   value,
	output logic                      strobe,
	output logic signed [VAL_W-1:0]   value_res,
	output logic [STAT_W-1:0]         status,
	output logic                      last,
	output logic [COUNT_W-1:0]        count
);

	q_item_t q_item;
	logic    q_valid;
	logic    q_take;

	// Accept and decode
	dq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.value   (value),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_take  (q_take)
	);

	// Execute against the ring buffer
	dq_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.strobe    (strobe),
		.value_res (value_res),
		.status    (status),
		.last      (last),
		.count     (count)
	);

endmodule

// ===== test/tb.sv =====
// Self-checking bench for double_ended_queue_unit: a directed table, then random
// push/pop/dump traffic in fill, drain and mixed phases, checked by a behavioral deque.
// Depends on dq_pkg and the double_ended_queue_unit RTL.
module tb import dq_pkg::*;;

	// Codes outside the command set: the unit must drop them silently
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 330;
	localparam int TAB_ROWS     = 27;

	typedef struct packed {
		logic [VAL_W-1:0]   val;
		logic [STAT_W-1:0]  st;
		logic               lst;
		logic [COUNT_W-1:0] cnt;
	} dq_result_t;

	// One directed row: command, base value, repeat count, optional typed-in result
	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [VAL_W-1:0]   val;
		logic [7:0]         reps;
		logic               typed;
		logic [VAL_W-1:0]   exp_val;
		logic [STAT_W-1:0]  exp_st;
		logic [COUNT_W-1:0] exp_cnt;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [CMD_W-1:0]         cmd = '0;
	logic signed [VAL_W-1:0]  value = '0;
	logic                     strobe;
	logic signed [VAL_W-1:0]  value_res;
	logic [STAT_W-1:0]        status;
	logic                     last;
	logic [COUNT_W-1:0]       count;

	// Behavioral deque state
	logic [VAL_W-1:0] deque_mem [DQ_DEPTH];
	int               deque_front;
	int               deque_back;
	int               deque_count;

	dq_result_t       awaited_results [$];
	dir_row_t         dir_tab [TAB_ROWS];
	int               mismatches;
	int               burst_left;

	double_ended_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.value     (value),
		.strobe    (strobe),
		.value_res (value_res),
		.status    (status),
		.last      (last),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	task report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	function int ring_next(input int i);
		return (i + 1 >= DQ_DEPTH) ? 0 : i + 1;
	endfunction

	function int ring_prev(input int i);
		return (i == 0) ? DQ_DEPTH - 1 : i - 1;
	endfunction

	// Queue one expected result; count reflects the state after the operation
	function void await_result(input logic [VAL_W-1:0] v, input logic [STAT_W-1:0] st,
			input logic lst);
		dq_result_t r;
		r.val = v;
		r.st  = st;
		r.lst = lst;
		r.cnt = deque_count[COUNT_W-1:0];
		awaited_results.push_back(r);
	endfunction

	// Apply one accepted item to the deque and queue its results
	task automatic apply_deque_cmd(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v,
			output int n);
		int idx;
		int k;
		n = 0;
		case (c)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				n = 1;
				if (deque_count >= DQ_DEPTH) begin
					await_result('0, ST_FULL, 1'b1);
				end else begin
					if (c == CMD_PUSH_FRONT) begin
						deque_front = ring_prev(deque_front);
						deque_mem[deque_front] = v;
					end else begin
						deque_mem[deque_back] = v;
						deque_back = ring_next(deque_back);
					end
					deque_count++;
					await_result('0, ST_OK, 1'b1);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				n = 1;
				if (deque_count == 0) begin
					await_result('1, ST_EMPTY, 1'b1);
				end else begin
					if (c == CMD_POP_FRONT) begin
						idx = deque_front;
						deque_front = ring_next(deque_front);
					end else begin
						deque_back = ring_prev(deque_back);
						idx = deque_back;
					end
					deque_count--;
					await_result(deque_mem[idx], ST_OK, 1'b1);
				end
			end
			CMD_DUMP_FWD, CMD_DUMP_REV: begin
				if (deque_count == 0) begin
					n = 1;
					await_result('1, ST_EMPTY, 1'b1);
				end else begin
					n = deque_count;
					idx = (c == CMD_DUMP_FWD) ? deque_front : ring_prev(deque_back);
					for (k = 0; k < n; k++) begin
						await_result(deque_mem[idx], ST_OK, k + 1 == n);
						idx = (c == CMD_DUMP_FWD) ? ring_next(idx) : ring_prev(idx);
					end
				end
			end
			default: n = 0;
		endcase
	endtask

	// Hold start low, with a random value on the bus, for the length given by the cycles argument
	task pause_sender(input int cycles);
		start <= 1'b0;
		value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// Bursty sender: a random gap opens each new burst, some bursts run long
	task next_slot;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0)
				pause_sender(gap);
			burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 10);
		end
		burst_left--;
	endtask

	// Present one item, wait for acceptance, then predict its results
	task send_item(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v, output int n);
		start <= 1'b1;
		cmd   <= c;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		apply_deque_cmd(c, v, n);
	endtask

	// Stop sending until every awaited result is back
	task drain_results;
		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function logic [VAL_W-1:0] pick_value;
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Command mix; push_pct steers the fill level
	function logic [CMD_W-1:0] pick_cmd(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
		if (r < 11)
			return $urandom_range(0, 1) ? CMD_DUMP_FWD : CMD_DUMP_REV;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
	endfunction

	// Result checker: results cannot be held off, so check every strobe
	always @(posedge clk) begin
		dq_result_t e;
		if (arst_n && strobe === 1'b1) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%h status=%0d",
					value_res, status));
			end else begin
				e = awaited_results.pop_front();
				if (value_res !== e.val)
					report_mismatch($sformatf("value_res %h, want %h", value_res, e.val));
				if (status !== e.st)
					report_mismatch($sformatf("status %0d, want %0d", status, e.st));
				if (last !== e.lst)
					report_mismatch($sformatf("last %b, want %b", last, e.lst));
				if (count !== e.cnt)
					report_mismatch($sformatf("count %0d, want %0d", count, e.cnt));
			end
		end
	end

	initial begin
		int n;
		int r;
		int k;
		int sent;
		int phase_len;
		int push_pct;
		int first_phase;
		dq_result_t typed_res;
		logic [CMD_W-1:0] c;

		mismatches = 0;
		burst_left = 0;
		deque_front = 0;
		deque_back = 0;
		deque_count = 0;

		// Directed table: empty cases, unused codes, extremes, wrap, full
		dir_tab[0]  = '{CMD_POP_FRONT,  32'h0,         8'd1,  1'b1, '1, ST_EMPTY, 6'd0};
		dir_tab[1]  = '{CMD_POP_BACK,   32'h0,         8'd1,  1'b1, '1, ST_EMPTY, 6'd0};
		dir_tab[2]  = '{CMD_DUMP_FWD,   32'h0,         8'd1,  1'b1, '1, ST_EMPTY, 6'd0};
		dir_tab[3]  = '{CMD_DUMP_REV,   32'h0,         8'd1,  1'b1, '1, ST_EMPTY, 6'd0};
		dir_tab[4]  = '{CMD_SPARE_6,    32'hFFFF_FFFF, 8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[5]  = '{CMD_SPARE_7,    32'h5555_AAAA, 8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[6]  = '{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 8'd1,  1'b1, '0, ST_OK, 6'd1};
		dir_tab[7]  = '{CMD_PUSH_BACK,  32'h8000_0000, 8'd1,  1'b1, '0, ST_OK, 6'd2};
		dir_tab[8]  = '{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 8'd1,  1'b1, '0, ST_OK, 6'd3};
		dir_tab[9]  = '{CMD_PUSH_BACK,  32'h0000_0000, 8'd1,  1'b1, '0, ST_OK, 6'd4};
		dir_tab[10] = '{CMD_DUMP_FWD,   32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[11] = '{CMD_DUMP_REV,   32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[12] = '{CMD_POP_FRONT,  32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[13] = '{CMD_POP_BACK,   32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[14] = '{CMD_POP_BACK,   32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[15] = '{CMD_POP_FRONT,  32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[16] = '{CMD_POP_FRONT,  32'h0,         8'd1,  1'b1, '1, ST_EMPTY, 6'd0};
		dir_tab[17] = '{CMD_PUSH_BACK,  32'h1000_0000, 8'd32, 1'b0, '0, ST_OK, 6'd0};
		dir_tab[18] = '{CMD_PUSH_FRONT, 32'hDEAD_0001, 8'd1,  1'b1, '0, ST_FULL, 6'd32};
		dir_tab[19] = '{CMD_PUSH_BACK,  32'hDEAD_0002, 8'd1,  1'b1, '0, ST_FULL, 6'd32};
		dir_tab[20] = '{CMD_DUMP_FWD,   32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[21] = '{CMD_DUMP_REV,   32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};
		dir_tab[22] = '{CMD_POP_FRONT,  32'h0,         8'd16, 1'b0, '0, ST_OK, 6'd0};
		dir_tab[23] = '{CMD_POP_BACK,   32'h0,         8'd16, 1'b0, '0, ST_OK, 6'd0};
		dir_tab[24] = '{CMD_POP_BACK,   32'h0,         8'd1,  1'b1, '1, ST_EMPTY, 6'd0};
		dir_tab[25] = '{CMD_PUSH_FRONT, 32'hA5A5_0000, 8'd32, 1'b0, '0, ST_OK, 6'd0};
		dir_tab[26] = '{CMD_DUMP_REV,   32'h0,         8'd1,  1'b0, '0, ST_OK, 6'd0};

		// Reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; typed rows replace the predicted result
		for (r = 0; r < TAB_ROWS; r++) begin
			for (k = 0; k < dir_tab[r].reps; k++) begin
				next_slot();
				send_item(dir_tab[r].cmd, dir_tab[r].val + k, n);
				if (dir_tab[r].typed) begin
					repeat (n) awaited_results.pop_back();
					typed_res.val = dir_tab[r].exp_val;
					typed_res.st  = dir_tab[r].exp_st;
					typed_res.lst = 1'b1;
					typed_res.cnt = dir_tab[r].exp_cnt;
					awaited_results.push_back(typed_res);
				end
			end
		end

		// Random part: phases that fill, drain or churn the deque
		sent = 0;
		first_phase = 1;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: push_pct = 75;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			phase_len = $urandom_range(20, 60);
			while (phase_len > 0 && sent < RANDOM_ITEMS) begin
				c = pick_cmd(push_pct);
				next_slot();
				send_item(c, pick_value(), n);
				if (c != CMD_SPARE_6 && c != CMD_SPARE_7) begin
					sent++;
					phase_len--;
				end
			end
			// After the first phase, and after a random third of later ones, the sender holds off until the unit has gone quiet
			if (first_phase || $urandom_range(0, 2) == 0) begin
				drain_results();
				first_phase = 0;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== double_ended_queue_unit.f =====
design/dq_pkg.sv
design/dq_ram.sv
design/dq_front.sv
design/dq_back.sv
design/double_ended_queue_unit.sv
test/tb.sv
